// ----- hw/rtl/bets_pkg.sv -----
package bets_pkg;

	localparam int DATA_W = 48;
	localparam int CFG_W  = 47;
	localparam int IDX_W  = 3;
	localparam int PROD_W = 100;

	localparam logic [DATA_W-1:0] MAG_LIMIT = 48'h8000_0000_0000;
	localparam logic [CFG_W-1:0]  MAX47     = 47'h7FFF_FFFF_FFFF;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_AXIAL     = 3'd0;
	localparam logic [IDX_W-1:0] REG_TORSIONAL = 3'd1;
	localparam logic [IDX_W-1:0] REG_BEND_Y    = 3'd2;
	localparam logic [IDX_W-1:0] REG_BEND_Z    = 3'd3;

	// multiplier job tags, issued in this order
	localparam int TAG_W = 4;
	localparam logic [TAG_W-1:0] TAG_SS  = 4'd0;
	localparam logic [TAG_W-1:0] TAG_Y6  = 4'd1;
	localparam logic [TAG_W-1:0] TAG_Z6  = 4'd2;
	localparam logic [TAG_W-1:0] TAG_F0  = 4'd3;
	localparam logic [TAG_W-1:0] TAG_F1  = 4'd4;
	localparam logic [TAG_W-1:0] TAG_F2  = 4'd5;
	localparam logic [TAG_W-1:0] TAG_F3  = 4'd6;
	localparam logic [TAG_W-1:0] TAG_Y12 = 4'd7;
	localparam logic [TAG_W-1:0] TAG_Z12 = 4'd8;

	localparam logic [4:0] LAST_IDX = 5'd23;
	localparam logic [3:0] LAST_ROW = 4'd11;

	typedef enum logic [1:0] {
		SC_ONE,
		SC_SIX,
		SC_TWELVE
	} scale_t;

	// signed value from sign and magnitude, saturated to 48 bits
	function automatic logic signed [DATA_W-1:0] sval(input logic neg,
		input logic [DATA_W-1:0] mag);
		logic signed [DATA_W-1:0] res;
		if (neg) begin
			res = (mag >= MAG_LIMIT) ? signed'(MAG_LIMIT) : signed'(DATA_W'(-mag));
		end else begin
			res = (mag[DATA_W-1]) ? signed'({1'b0, MAX47}) : signed'(mag);
		end
		return res;
	endfunction

	// 2x / 4x of a stiffness, capped at 2^47-1
	function automatic logic signed [DATA_W-1:0] cap47(input logic [CFG_W+1:0] v);
		logic signed [DATA_W-1:0] res;
		if (|v[CFG_W+1:CFG_W]) begin
			res = signed'({1'b0, MAX47});
		end else begin
			res = signed'({1'b0, v[CFG_W-1:0]});
		end
		return res;
	endfunction

endpackage

// ----- hw/rtl/beam_element_tangent_stiffness.sv -----
// Corotational 3D beam element: local 12x12 tangent stiffness matrix.
//
// Configuration: write axial, torsional and the two bending stiffnesses through
// cfg_we / cfg_index / cfg_data while the block is idle. Indexes 4..7 are ignored.
// Input channel (in_valid / in_ready): one element state per transfer, the current
// length, the operation bit and four internal forces.
// Output channel (out_valid / out_ready): 24 half-row transfers per element, row 0
// half 0 first, last set on row 11 half 1.
//
// In the compute engine a radix-8 restoring divider forms 1/length (three quotient
// bits a cycle), then nine products go through a three-stage 48x47 multiplier
// built from four 24x24 parts. The emitter streams one element while the engine
// computes the next and an input buffer holds a third.
// Reset clears the configuration to zero and empties every stage. When out_ready
// is low the output register holds; the engine and input buffer fill up and then
// in_ready drops. Nothing is lost or repeated.
module beam_element_tangent_stiffness
	import bets_pkg::*;
#(
	parameter int FRACTION_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     operation,
	input  logic [CFG_W-1:0]         current_length,
	input  logic signed [DATA_W-1:0] force_a_y,
	input  logic signed [DATA_W-1:0] force_a_z,
	input  logic signed [DATA_W-1:0] force_b_y,
	input  logic signed [DATA_W-1:0] force_b_z,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [3:0]               row,
	output logic                     column_half,
	output logic signed [DATA_W-1:0] value_0,
	output logic signed [DATA_W-1:0] value_1,
	output logic signed [DATA_W-1:0] value_2,
	output logic signed [DATA_W-1:0] value_3,
	output logic signed [DATA_W-1:0] value_4,
	output logic signed [DATA_W-1:0] value_5,
	output logic                     last
);

	localparam int DivSteps    = 2 * FRACTION_BITS + 1;
	localparam int DivPerCycle = 3;
	localparam int StepW       = $clog2(DivSteps + DivPerCycle + 1);
	localparam logic [PROD_W-1:0] RoundHalf = PROD_W'(1) << (FRACTION_BITS - 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	// configuration
	logic [CFG_W-1:0] axial_q, tors_q, bend_y_q, bend_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axial_q  <= '0;
			tors_q   <= '0;
			bend_y_q <= '0;
			bend_z_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AXIAL:     axial_q  <= cfg_data;
				REG_TORSIONAL: tors_q   <= cfg_data;
				REG_BEND_Y:    bend_y_q <= cfg_data;
				REG_BEND_Z:    bend_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input buffer
	logic                     buf_valid_q;
	logic                     buf_op_q;
	logic [CFG_W-1:0]         buf_len_q;
	logic signed [DATA_W-1:0] buf_f_q [4];
	logic                     eng_take;

	assign in_ready = !buf_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			buf_valid_q <= 1'b1;
		end else if (eng_take) begin
			buf_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			buf_op_q   <= operation;
			buf_len_q  <= current_length;
			buf_f_q[0] <= force_a_y;
			buf_f_q[1] <= force_a_z;
			buf_f_q[2] <= force_b_y;
			buf_f_q[3] <= force_b_z;
		end
	end

	// compute engine
	state_t           state_q;
	logic [StepW-1:0] step_q;
	logic [CFG_W:0]   rem_q, rem_c, sh;
	logic [CFG_W-1:0] quo_q, quo_c, s_next;
	logic             ov_q, ov_c, dbit;
	logic [CFG_W-1:0] len_q, s_q, ss_q;
	logic             op_q;
	logic             fneg_q [4];
	logic [DATA_W-1:0] fmag_q [4];
	logic [DATA_W-1:0] y6_q, z6_q, y12_q, z12_q;
	logic [DATA_W-1:0] p_q [4];
	logic [TAG_W-1:0] iss_q;
	logic             bank_free, emit_go, bank_load;

	always_comb begin
		rem_c = rem_q;
		quo_c = quo_q;
		ov_c  = ov_q;
		sh    = '0;
		dbit  = 1'b0;
		for (int k = 0; k < DivPerCycle; k++) begin
			if (int'(step_q) + k < DivSteps) begin
				sh   = {rem_c[CFG_W-1:0], (int'(step_q) + k == 0)};
				dbit = (sh >= {1'b0, len_q});
				rem_c = dbit ? (sh - {1'b0, len_q}) : sh;
				ov_c  = ov_c | quo_c[CFG_W-1];
				quo_c = {quo_c[CFG_W-2:0], dbit};
			end
		end
		s_next = ((len_q == '0) || ov_c) ? MAX47 : quo_c;
	end

	assign eng_take  = buf_valid_q &&
		((state_q == ST_IDLE) || (state_q == ST_DONE && bank_free));
	assign bank_load = (state_q == ST_DONE) && bank_free;

	// multiplier pipeline signals
	logic                     v_s1, v_s2, v_s3;
	logic [TAG_W-1:0]         tag_s1, tag_s2, tag_s3;
	scale_t                   scl_s1, scl_s2;
	logic [2*24-1:0]          pp_ll_s1, pp_lh_s1, pp_hl_s1, pp_hh_s1;
	logic [95:0]              sum_s2;
	logic [DATA_W-1:0]        mag_s3;
	logic [DATA_W-1:0]        op_a;
	logic [DATA_W-1:0]        op_b;
	scale_t                   op_scl;
	logic                     issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			iss_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (eng_take) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end
				end
				ST_DIV: begin
					step_q <= step_q + StepW'(DivPerCycle);
					if (int'(step_q) + DivPerCycle >= DivSteps) begin
						state_q <= ST_MUL;
						iss_q   <= '0;
					end
				end
				ST_MUL: begin
					if (issue) begin
						iss_q <= iss_q + 1'b1;
					end
					if (v_s3 && tag_s3 == TAG_Z12) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (eng_take) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end else if (bank_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (eng_take) begin
			op_q  <= buf_op_q;
			len_q <= buf_len_q;
			rem_q <= '0;
			quo_q <= '0;
			ov_q  <= 1'b0;
			for (int k = 0; k < 4; k++) begin
				fneg_q[k] <= buf_f_q[k][DATA_W-1];
				fmag_q[k] <= buf_f_q[k][DATA_W-1] ? DATA_W'(-buf_f_q[k]) : buf_f_q[k];
			end
		end else if (state_q == ST_DIV) begin
			rem_q <= rem_c;
			quo_q <= quo_c;
			ov_q  <= ov_c;
			s_q   <= s_next;
		end
		if (v_s3) begin
			case (tag_s3)
				TAG_SS:  ss_q  <= mag_s3[DATA_W-1] ? MAX47 : mag_s3[CFG_W-1:0];
				TAG_Y6:  y6_q  <= mag_s3;
				TAG_Z6:  z6_q  <= mag_s3;
				TAG_F0:  p_q[0] <= mag_s3;
				TAG_F1:  p_q[1] <= mag_s3;
				TAG_F2:  p_q[2] <= mag_s3;
				TAG_F3:  p_q[3] <= mag_s3;
				TAG_Y12: y12_q <= mag_s3;
				TAG_Z12: z12_q <= mag_s3;
				default: ;
			endcase
		end
	end

	// operand select for the multiplier job being issued
	assign issue = (state_q == ST_MUL) && (iss_q <= TAG_Z12);

	always_comb begin
		op_a   = '0;
		op_b   = {1'b0, s_q};
		op_scl = SC_ONE;
		case (iss_q)
			TAG_SS:  op_a = {1'b0, s_q};
			TAG_Y6: begin
				op_a   = {1'b0, bend_y_q};
				op_scl = SC_SIX;
			end
			TAG_Z6: begin
				op_a   = {1'b0, bend_z_q};
				op_scl = SC_SIX;
			end
			TAG_F0:  op_a = fmag_q[0];
			TAG_F1:  op_a = fmag_q[1];
			TAG_F2:  op_a = fmag_q[2];
			TAG_F3:  op_a = fmag_q[3];
			TAG_Y12: begin
				op_a   = {1'b0, bend_y_q};
				op_b   = {1'b0, ss_q};
				op_scl = SC_TWELVE;
			end
			TAG_Z12: begin
				op_a   = {1'b0, bend_z_q};
				op_b   = {1'b0, ss_q};
				op_scl = SC_TWELVE;
			end
			default: ;
		endcase
	end

	// three-stage multiplier: partial products, sum, scale and round
	logic [PROD_W-1:0] scaled, rnd, shifted;

	always_comb begin
		case (scl_s2)
			SC_SIX:    scaled = (PROD_W'(sum_s2) << 2) + (PROD_W'(sum_s2) << 1);
			SC_TWELVE: scaled = (PROD_W'(sum_s2) << 3) + (PROD_W'(sum_s2) << 2);
			default:   scaled = PROD_W'(sum_s2);
		endcase
		rnd     = scaled + RoundHalf;
		shifted = rnd >> FRACTION_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1   <= iss_q;
		scl_s1   <= op_scl;
		pp_ll_s1 <= 48'(op_a[23:0])  * 48'(op_b[23:0]);
		pp_lh_s1 <= 48'(op_a[23:0])  * 48'(op_b[47:24]);
		pp_hl_s1 <= 48'(op_a[47:24]) * 48'(op_b[23:0]);
		pp_hh_s1 <= 48'(op_a[47:24]) * 48'(op_b[47:24]);
		tag_s2   <= tag_s1;
		scl_s2   <= scl_s1;
		sum_s2   <= 96'(pp_ll_s1) + ((96'(pp_lh_s1) + 96'(pp_hl_s1)) << 24)
			+ (96'(pp_hh_s1) << 48);
		tag_s3   <= tag_s2;
		mag_s3   <= ((|shifted[PROD_W-1:DATA_W]) || (shifted[DATA_W-1:0] > MAG_LIMIT))
			? MAG_LIMIT : shifted[DATA_W-1:0];
	end

	// result bank read by the emitter
	logic                     bank_valid_q;
	logic [4:0]               idx_q;
	logic signed [DATA_W-1:0] y12p_q, y12n_q, y6p_q, y6n_q;
	logic signed [DATA_W-1:0] z12p_q, z12n_q, z6p_q, z6n_q;
	logic signed [DATA_W-1:0] st0_q [4];
	logic signed [DATA_W-1:0] st6_q [4];

	assign emit_go   = bank_valid_q && (!out_valid || out_ready);
	assign bank_free = !bank_valid_q || (emit_go && idx_q == LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_valid_q <= 1'b0;
			idx_q        <= '0;
		end else begin
			if (bank_load) begin
				bank_valid_q <= 1'b1;
			end else if (bank_free) begin
				bank_valid_q <= 1'b0;
			end
			if (emit_go) begin
				idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bank_load) begin
			y12p_q <= sval(1'b0, y12_q);
			y12n_q <= sval(1'b1, y12_q);
			y6p_q  <= sval(1'b0, y6_q);
			y6n_q  <= sval(1'b1, y6_q);
			z12p_q <= sval(1'b0, z12_q);
			z12n_q <= sval(1'b1, z12_q);
			z6p_q  <= sval(1'b0, z6_q);
			z6n_q  <= sval(1'b1, z6_q);
			for (int k = 0; k < 4; k++) begin
				st0_q[k] <= op_q ? sval(fneg_q[k], p_q[k]) : '0;
				st6_q[k] <= op_q ? sval(!fneg_q[k], p_q[k]) : '0;
			end
		end
	end

	// half-row assembly
	logic signed [DATA_W-1:0] rowv [12];
	logic signed [DATA_W-1:0] a_p, a_n, t_p, t_n, y4, y2, z4, z2;

	always_comb begin
		a_p = signed'({1'b0, axial_q});
		a_n = -a_p;
		t_p = signed'({1'b0, tors_q});
		t_n = -t_p;
		y4  = cap47({bend_y_q, 2'b00});
		y2  = cap47({1'b0, bend_y_q, 1'b0});
		z4  = cap47({bend_z_q, 2'b00});
		z2  = cap47({1'b0, bend_z_q, 1'b0});
		for (int c = 0; c < 12; c++) begin
			rowv[c] = '0;
		end
		case (idx_q[4:1])
			4'd0: begin
				rowv[0] = a_p; rowv[6] = a_n;
			end
			4'd1: begin
				rowv[0] = st0_q[0]; rowv[6] = st6_q[0];
				rowv[1] = z12p_q; rowv[7] = z12n_q; rowv[5] = z6p_q; rowv[11] = z6p_q;
			end
			4'd2: begin
				rowv[0] = st0_q[1]; rowv[6] = st6_q[1];
				rowv[2] = y12p_q; rowv[8] = y12n_q; rowv[4] = y6n_q; rowv[10] = y6n_q;
			end
			4'd3: begin
				rowv[3] = t_p; rowv[9] = t_n;
			end
			4'd4: begin
				rowv[2] = y6n_q; rowv[8] = y6p_q; rowv[4] = y4; rowv[10] = y2;
			end
			4'd5: begin
				rowv[1] = z6p_q; rowv[7] = z6n_q; rowv[5] = z4; rowv[11] = z2;
			end
			4'd6: begin
				rowv[0] = a_n; rowv[6] = a_p;
			end
			4'd7: begin
				rowv[0] = st0_q[2]; rowv[6] = st6_q[2];
				rowv[1] = z12n_q; rowv[7] = z12p_q; rowv[5] = z6n_q; rowv[11] = z6n_q;
			end
			4'd8: begin
				rowv[0] = st0_q[3]; rowv[6] = st6_q[3];
				rowv[2] = y12n_q; rowv[8] = y12p_q; rowv[4] = y6p_q; rowv[10] = y6p_q;
			end
			4'd9: begin
				rowv[3] = t_n; rowv[9] = t_p;
			end
			4'd10: begin
				rowv[2] = y6n_q; rowv[8] = y6p_q; rowv[4] = y2; rowv[10] = y4;
			end
			4'd11: begin
				rowv[1] = z6p_q; rowv[7] = z6n_q; rowv[5] = z2; rowv[11] = z4;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit_go) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			row         <= idx_q[4:1];
			column_half <= idx_q[0];
			last        <= (idx_q == LAST_IDX);
			value_0     <= idx_q[0] ? rowv[6]  : rowv[0];
			value_1     <= idx_q[0] ? rowv[7]  : rowv[1];
			value_2     <= idx_q[0] ? rowv[8]  : rowv[2];
			value_3     <= idx_q[0] ? rowv[9]  : rowv[3];
			value_4     <= idx_q[0] ? rowv[10] : rowv[4];
			value_5     <= idx_q[0] ? rowv[11] : rowv[5];
		end
	end

	// checks
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> row == LAST_ROW && column_half)
		else $error("last flag away from final half-row");

	a_bank_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		bank_load |-> !bank_valid_q || (emit_go && idx_q == LAST_IDX))
		else $error("result bank overwritten while emitting");

	a_mul_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> $past(state_q) == ST_MUL)
		else $error("multiplier job issued outside the multiply phase");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= LAST_IDX)
		else $error("half-row index out of range");

endmodule
